// File: rtl/binary_min_heap_queue_defines.svh
// Assertion macros of the port-level checker of the binary min-heap queue.
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define BMHQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BMHQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bmhq_pkg.sv
// Shared types and codes of the binary min-heap queue.
package bmhq_pkg;

  localparam int KEY_W  = 32;
  localparam int PAY_W  = 16;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } entry_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_RM_ROOT,
    S_RM_LAST,
    S_RM_X,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_FIN_RD,
    S_FIN_OUT
  } state_t;

endpackage

// File: rtl/bmhq_ram.sv
// Heap entry store: one write port, one read port with registered read data.
module bmhq_ram import bmhq_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/bmhq_ctrl.sv
// Request sequencer: sift-up and sift-down over the entry store, result register.
module bmhq_ctrl import bmhq_pkg::*; #(
  parameter int CAPACITY = 256,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [KEY_W-1:0]  key,
  input  logic [PAY_W-1:0]  payload,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [KEY_W-1:0]  removed_key,
  output logic [PAY_W-1:0]  removed_payload,
  output logic              min_valid,
  output logic [KEY_W-1:0]  min_key,
  output logic [PAY_W-1:0]  min_payload,
  output logic [CNT_W-1:0]  entry_count,
  output logic              mem_rd_en,
  output logic [AW-1:0]     mem_rd_addr,
  input  entry_t            mem_rd_data,
  output logic              mem_wr_en,
  output logic [AW-1:0]     mem_wr_addr,
  output entry_t            mem_wr_data
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] pos;
  entry_t           x_ent;
  entry_t           left_ent;
  entry_t           rem_ent;
  status_t          stat;

  logic [CNT_W:0] pos_ext, parent_ext, child, right_idx, cnt_ext, pick_idx;
  logic           has_child, has_right, take_right, out_free;
  entry_t         pick;

  // Slot numbers are 1-based; the store is addressed from zero.
  function automatic logic [AW-1:0] addr_of(input logic [CNT_W:0] p);
    logic [CNT_W:0] a;
    a = p - (CNT_W + 1)'(1);
    return a[AW-1:0];
  endfunction

  assign pos_ext    = {1'b0, pos};
  assign parent_ext = {2'b00, pos[CNT_W-1:1]};
  assign child      = {pos, 1'b0};
  assign right_idx  = {pos, 1'b1};
  assign cnt_ext    = {1'b0, cnt};
  assign has_child  = child <= cnt_ext;
  assign has_right  = right_idx <= cnt_ext;
  // Right child wins only when strictly smaller, which keeps tie layout fixed.
  assign take_right = has_right && (mem_rd_data.key < left_ent.key);
  assign pick       = take_right ? mem_rd_data : left_ent;
  assign pick_idx   = take_right ? right_idx : child;
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = x_ent;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (req_t'(req_type))
            REQ_INSERT: state_next = (cnt == CAP_CNT) ? S_FIN_RD : S_INS_RD;
            REQ_REMOVE: state_next = (cnt == '0) ? S_FIN_RD : S_RM_ROOT;
            default:    state_next = S_FIN_RD;
          endcase
        end
      end
      S_INS_RD: begin
        if (pos == ONE_CNT) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = addr_of(pos_ext);
          state_next  = S_FIN_RD;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = addr_of(parent_ext);
          state_next  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = addr_of(pos_ext);
        if (x_ent.key < mem_rd_data.key) begin
          mem_wr_data = mem_rd_data;
          state_next  = S_INS_RD;
        end else begin
          state_next  = S_FIN_RD;
        end
      end
      S_RM_ROOT: begin
        mem_rd_en  = 1'b1;
        state_next = S_RM_LAST;
      end
      S_RM_LAST: begin
        if (cnt == '0) begin
          state_next = S_FIN_RD;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = cnt[AW-1:0];
          state_next  = S_RM_X;
        end
      end
      S_RM_X: state_next = S_DN_CHK;
      S_DN_CHK: begin
        if (has_child) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = addr_of(child);
          state_next  = S_DN_L;
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = addr_of(pos_ext);
          state_next  = S_FIN_RD;
        end
      end
      S_DN_L: begin
        // The right child sits one slot past the left one.
        mem_rd_en   = 1'b1;
        mem_rd_addr = child[AW-1:0];
        state_next  = S_DN_R;
      end
      S_DN_R: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = addr_of(pos_ext);
        if (x_ent.key > pick.key) begin
          mem_wr_data = pick;
          state_next  = S_DN_CHK;
        end else begin
          state_next  = S_FIN_RD;
        end
      end
      S_FIN_RD: begin
        mem_rd_en  = 1'b1;
        state_next = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE && in_valid) begin
        unique case (req_t'(req_type))
          REQ_INSERT: if (cnt != CAP_CNT) cnt <= cnt + ONE_CNT;
          REQ_REMOVE: if (cnt != '0) cnt <= cnt - ONE_CNT;
          REQ_CLEAR:  cnt <= '0;
          default:    cnt <= cnt;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          stat    <= STAT_OK;
          rem_ent <= '0;
          x_ent   <= '{key: key, pay: payload};
          pos     <= cnt + ONE_CNT;
          if (req_t'(req_type) == REQ_INSERT && cnt == CAP_CNT) begin
            stat <= STAT_FULL;
          end
          if (req_t'(req_type) == REQ_REMOVE && cnt == '0) begin
            stat <= STAT_EMPTY;
          end
        end
      end
      S_INS_CMP: begin
        if (x_ent.key < mem_rd_data.key) begin
          pos <= parent_ext[CNT_W-1:0];
        end
      end
      S_RM_LAST: rem_ent <= mem_rd_data;
      S_RM_X: begin
        x_ent <= mem_rd_data;
        pos   <= ONE_CNT;
      end
      S_DN_L: left_ent <= mem_rd_data;
      S_DN_R: begin
        if (x_ent.key > pick.key) begin
          pos <= pick_idx[CNT_W-1:0];
        end
      end
      S_FIN_OUT: begin
        if (out_free) begin
          status          <= stat;
          removed_key     <= rem_ent.key;
          removed_payload <= rem_ent.pay;
          min_valid       <= (cnt != '0);
          min_key         <= (cnt != '0) ? mem_rd_data.key : '0;
          min_payload     <= (cnt != '0) ? mem_rd_data.pay : '0;
          entry_count     <= cnt;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/binary_min_heap_queue.sv
// Top level of the binary min-heap priority queue.
//
// Request channel (in_valid / in_ready): one beat carries req_type, key and
// payload. Insert places the entry and sifts it up, remove takes the root and
// sifts the last entry down from the root, clear empties the heap. An
// undefined request code leaves the heap as it is.
// Result channel (out_valid / out_ready): exactly one beat per request, with
// status, the removed entry (zero when nothing was removed), the root after
// the request (zero when empty) and the entry count.
// Requests are handled one at a time, paced by the single read port of the
// entry store. An insert takes longer the more levels it climbs, a remove
// the more levels it descends; a remove that takes the last entry, clear, an
// undefined code and a refused request do no sift at all.
// A new request is taken while the previous result still waits; a stalled
// receiver holds the finished result, and the block waits before it writes
// the next one. Reset empties the heap at once: the store needs no clearing
// pass, since only slots up to the entry count are ever used.
module binary_min_heap_queue import bmhq_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [REQ_W-1:0]                  req_type,
  input  logic [KEY_W-1:0]                  key,
  input  logic [PAY_W-1:0]                  payload,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [STAT_W-1:0]                 status,
  output logic [KEY_W-1:0]                  removed_key,
  output logic [PAY_W-1:0]                  removed_payload,
  output logic                              min_valid,
  output logic [KEY_W-1:0]                  min_key,
  output logic [PAY_W-1:0]                  min_payload,
  output logic [$clog2(CAPACITY + 1)-1:0]   entry_count
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Store port between the sequencer and the entry memory.
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;

  bmhq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // The sequencer never reads a slot in the cycle it writes it, so the store
  // needs no forwarding path.
  bmhq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .key             (key),
    .payload         (payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .removed_key     (removed_key),
    .removed_payload (removed_payload),
    .min_valid       (min_valid),
    .min_key         (min_key),
    .min_payload     (min_payload),
    .entry_count     (entry_count),
    .mem_rd_en       (rd_en),
    .mem_rd_addr     (rd_addr),
    .mem_rd_data     (rd_data),
    .mem_wr_en       (wr_en),
    .mem_wr_addr     (wr_addr),
    .mem_wr_data     (wr_data)
  );

endmodule

// File: rtl/bmhq_checker.sv
// Port-level checks of the binary min-heap queue and their binding.
`include "binary_min_heap_queue_defines.svh"

module bmhq_checker import bmhq_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [REQ_W-1:0]                req_type,
  input logic [KEY_W-1:0]                key,
  input logic [PAY_W-1:0]                payload,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [STAT_W-1:0]               status,
  input logic [KEY_W-1:0]                removed_key,
  input logic [PAY_W-1:0]                removed_payload,
  input logic                            min_valid,
  input logic [KEY_W-1:0]                min_key,
  input logic [PAY_W-1:0]                min_payload,
  input logic [$clog2(CAPACITY + 1)-1:0] entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  `BMHQ_ASSERT_ALWAYS(a_no_result_after_reset, rst |=> !out_valid, "result beat right after reset")

  `BMHQ_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(min_key) && $stable(entry_count), "stalled result changed")

  `BMHQ_ASSERT(a_min_matches_count, out_valid |-> (min_valid == (entry_count != '0)) && (min_valid || (min_key == '0 && min_payload == '0)), "root report disagrees with count")

  `BMHQ_ASSERT(a_refused_insert, out_valid && status == STAT_FULL |-> entry_count == CNT_W'(CAPACITY) && removed_key == '0 && removed_payload == '0, "full status with room left")

  `BMHQ_ASSERT(a_empty_remove, out_valid && status == STAT_EMPTY |-> entry_count == '0 && !min_valid && removed_key == '0, "empty status on a nonempty heap")

endmodule

bind binary_min_heap_queue bmhq_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

// File: test/heap_queue_checker.sv
// Result checker for the binary min-heap queue: shadow heap, expected beats, compare.
`timescale 1ns / 1ps

module heap_queue_checker import bmhq_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [REQ_W-1:0]                req_type,
  input  logic [KEY_W-1:0]                key,
  input  logic [PAY_W-1:0]                payload,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [STAT_W-1:0]               status,
  input  logic [KEY_W-1:0]                removed_key,
  input  logic [PAY_W-1:0]                removed_payload,
  input  logic                            min_valid,
  input  logic [KEY_W-1:0]                min_key,
  input  logic [PAY_W-1:0]                min_payload,
  input  logic [$clog2(CAPACITY + 1)-1:0] entry_count,
  output int                              mismatch_count,
  output int                              outstanding
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] removed_key;
    logic [PAY_W-1:0] removed_pay;
    logic             min_valid;
    logic [KEY_W-1:0] min_key;
    logic [PAY_W-1:0] min_pay;
    logic [CNT_W-1:0] count;
  } heap_reply_t;

  // Shadow copy of the heap, 1-based like the block's slot numbers.
  entry_t      shadow_heap [1:CAPACITY];
  int          shadow_fill = 0;
  heap_reply_t expected_replies [$];
  int          fails = 0;

  // Applies one request to the shadow heap and returns the beat it must produce.
  function automatic heap_reply_t predict_reply(logic [REQ_W-1:0] req,
                                                logic [KEY_W-1:0] k,
                                                logic [PAY_W-1:0] p);
    heap_reply_t r;
    entry_t      moving;
    int          pos;
    int          child;
    r = '0;
    case (req)
      REQ_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          shadow_fill++;
          pos = shadow_fill;
          moving.key = k;
          moving.pay = p;
          while (pos > 1 && moving.key < shadow_heap[pos / 2].key) begin
            shadow_heap[pos] = shadow_heap[pos / 2];
            pos = pos / 2;
          end
          shadow_heap[pos] = moving;
        end
      end
      REQ_REMOVE: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.removed_key = shadow_heap[1].key;
          r.removed_pay = shadow_heap[1].pay;
          moving = shadow_heap[shadow_fill];
          shadow_fill--;
          if (shadow_fill > 0) begin
            pos = 1;
            while (pos * 2 <= shadow_fill) begin
              child = pos * 2;
              if (child + 1 <= shadow_fill &&
                  shadow_heap[child + 1].key < shadow_heap[child].key) begin
                child++;
              end
              if (moving.key > shadow_heap[child].key) begin
                shadow_heap[pos] = shadow_heap[child];
                pos = child;
              end else begin
                break;
              end
            end
            shadow_heap[pos] = moving;
          end
        end
      end
      REQ_CLEAR: begin
        shadow_fill = 0;
      end
      default: begin
      end
    endcase
    if (shadow_fill > 0) begin
      r.min_valid = 1'b1;
      r.min_key   = shadow_heap[1].key;
      r.min_pay   = shadow_heap[1].pay;
    end
    r.count = shadow_fill[CNT_W-1:0];
    return r;
  endfunction

  function automatic string reply_text(heap_reply_t r);
    return $sformatf("status=%0d rkey=%h rpay=%h mvalid=%b mkey=%h mpay=%h count=%0d",
                     r.status, r.removed_key, r.removed_pay, r.min_valid,
                     r.min_key, r.min_pay, r.count);
  endfunction

  always @(posedge clk) begin : watch
    heap_reply_t got;
    heap_reply_t want;
    if (rst) begin
      shadow_fill = 0;
      expected_replies.delete();
    end else begin
      // The result beat is retired first: it can never belong to a request
      // accepted at the same edge.
      if (out_valid && out_ready) begin
        got.status      = status_t'(status);
        got.removed_key = removed_key;
        got.removed_pay = removed_payload;
        got.min_valid   = min_valid;
        got.min_key     = min_key;
        got.min_pay     = min_payload;
        got.count       = entry_count;
        if (expected_replies.size() == 0) begin
          if (fails < 10) $display("%0t: result beat with no request pending: %s",
                                   $realtime, reply_text(got));
          fails++;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status || got.removed_key !== want.removed_key ||
              got.removed_pay !== want.removed_pay || got.min_valid !== want.min_valid ||
              got.min_key !== want.min_key || got.min_pay !== want.min_pay ||
              got.count !== want.count) begin
            if (fails < 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", reply_text(want));
              $display("  actual   %s", reply_text(got));
            end
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_replies = {expected_replies, predict_reply(req_type, key, payload)};
      end
    end
    mismatch_count <= fails;
    outstanding    <= expected_replies.size();
  end

endmodule

// File: test/tb_binary_min_heap_queue.sv
// Testbench top for the binary min-heap queue: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_binary_min_heap_queue;
  import bmhq_pkg::*;

  localparam int HEAP_CAPACITY = 256;
  localparam int CNT_W         = $clog2(HEAP_CAPACITY + 1);
  // Request code the block does not define; it must leave the heap untouched.
  localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;
  localparam int MAX_GAP      = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  // The slowest legal run is roughly 460 beats with their widest gaps and
  // sifts, plus the long hold-off; the limit leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [REQ_W-1:0]   req_type = '0;
  logic [KEY_W-1:0]   key = '0;
  logic [PAY_W-1:0]   payload = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [STAT_W-1:0]  status;
  logic [KEY_W-1:0]   removed_key;
  logic [PAY_W-1:0]   removed_payload;
  logic               min_valid;
  logic [KEY_W-1:0]   min_key;
  logic [PAY_W-1:0]   min_payload;
  logic [CNT_W-1:0]   entry_count;

  int          mismatch_count;
  int          outstanding;
  int unsigned cycle_count = 0;

  // When pace_gaps is low both sides run back to back; when high each beat
  // waits a random gap of up to MAX_GAP on either side.
  bit pace_gaps = 1'b0;
  // Raised by the stimulus process to ask the result side for one long stall.
  bit hold_request = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary_min_heap_queue #(.CAPACITY(HEAP_CAPACITY)) i_dut (
    .clk, .rst,
    .in_valid, .in_ready, .req_type, .key, .payload,
    .out_valid, .out_ready, .status, .removed_key, .removed_payload,
    .min_valid, .min_key, .min_payload, .entry_count
  );

  heap_queue_checker #(.CAPACITY(HEAP_CAPACITY)) i_checker (
    .clk, .rst,
    .in_valid, .in_ready, .req_type, .key, .payload,
    .out_valid, .out_ready, .status, .removed_key, .removed_payload,
    .min_valid, .min_key, .min_payload, .entry_count,
    .mismatch_count, .outstanding
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[binary_min_heap_queue] ERROR");
      $finish;
    end
  end

  // Offers one request beat. The task is entered at a clock edge; valid is
  // only dropped when a gap really follows, so it is never lowered and raised
  // again within one time step.
  task automatic offer_request(input logic [REQ_W-1:0] req,
                               input logic [KEY_W-1:0] k,
                               input logic [PAY_W-1:0] p);
    int gap;
    gap = pace_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    key      <= k;
    payload  <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // Small keys give plenty of ties, which is where the sift rules matter;
  // about one key in four spans all 32 bits.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 12);
  endfunction

  // Mixed traffic, weighted toward inserts so the heap grows a few levels.
  task automatic run_mixed(input int beats);
    int               roll;
    logic [REQ_W-1:0] req;
    for (int i = 0; i < beats; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55)      req = REQ_INSERT;
      else if (roll < 93) req = REQ_REMOVE;
      else if (roll < 96) req = REQ_CLEAR;
      else                req = REQ_UNDEF;
      offer_request(req, pick_key(), PAY_W'($urandom));
    end
  endtask

  // Result side. Each beat waits a drawn number of cycles before ready rises;
  // on request it first holds ready low for a long stretch so that the
  // block finishes a result, cannot hand it over, and stops taking requests.
  initial begin : result_sink
    int stall;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = pace_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, back to back. It starts on an empty heap: remove on
    // empty, clear on empty and the undefined code, all carrying junk fields.
    offer_request(REQ_REMOVE, '1, '1);
    offer_request(REQ_CLEAR, 32'hA5A5_5A5A, 16'h5A5A);
    offer_request(REQ_UNDEF, 32'h1234_5678, 16'hBEEF);
    // Extreme keys and payloads, then a run of equal keys.
    offer_request(REQ_INSERT, '1, '1);
    offer_request(REQ_INSERT, '0, '0);
    offer_request(REQ_INSERT, 32'd5, 16'h00A1);
    offer_request(REQ_INSERT, 32'd5, 16'h00A2);
    offer_request(REQ_INSERT, 32'd5, 16'h00A3);
    // The undefined code on a populated heap must report it unchanged.
    offer_request(REQ_UNDEF, '1, '1);
    offer_request(REQ_INSERT, 32'd3, 16'h00B0);
    offer_request(REQ_REMOVE, '1, '1);
    offer_request(REQ_REMOVE, 32'h8000_0000, 16'h8000);
    offer_request(REQ_REMOVE, '0, '0);
    offer_request(REQ_INSERT, 32'd2, 16'h7FFF);
    // Drain completely: the final remove takes the last entry with no sift,
    // and the one after it finds the heap empty.
    repeat (4) offer_request(REQ_REMOVE, '0, '0);
    offer_request(REQ_REMOVE, '0, '0);
    offer_request(REQ_INSERT, 32'd1, 16'h0001);
    offer_request(REQ_INSERT, 32'd2, 16'h0002);
    offer_request(REQ_CLEAR, '1, '1);
    offer_request(REQ_REMOVE, '0, '0);

    // Random mixed traffic with idling on both sides. The long hold-off of
    // the result side lands at the start of this phase.
    pace_gaps    = 1'b1;
    hold_request = 1'b1;
    run_mixed(70);

    // Fill the heap to capacity back to back, then two refused inserts.
    pace_gaps = 1'b0;
    offer_request(REQ_CLEAR, KEY_W'($urandom), PAY_W'($urandom));
    repeat (HEAP_CAPACITY + 2) offer_request(REQ_INSERT, pick_key(), PAY_W'($urandom));

    // Mostly removes from the full heap, so sifts walk all eight levels.
    pace_gaps = 1'b1;
    for (int i = 0; i < 70; i++) begin
      offer_request(($urandom_range(0, 9) < 7) ? REQ_REMOVE : REQ_INSERT,
                    pick_key(), PAY_W'($urandom));
    end

    run_mixed(40);
    in_valid <= 1'b0;

    // Wait for every expected beat, then a little longer for any stray one.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[binary_min_heap_queue] OK");
    end else begin
      $display("[binary_min_heap_queue] ERROR");
    end
    $finish;
  end

endmodule
